// ===== hdl/lras_pkg.sv =====
package lras_pkg;

	localparam int unsigned ADDR_W  = 39;
	localparam int unsigned IDX_W   = 5;
	localparam int unsigned CSP_W   = 4;
	localparam int unsigned VBITS_W = 32;
	localparam int unsigned REQ_W   = 2;

	localparam int unsigned SPEC_ENTRIES_DEF   = 32;
	localparam int unsigned COMMIT_ENTRIES_DEF = 16;

	localparam logic [ADDR_W-1:0] RESET_ADDR = 39'h00_8000_0000;

	// request codes, the remaining code is ignored
	typedef enum logic [REQ_W-1:0] {
		REQ_PREDICT = 2'd0,
		REQ_RECOVER = 2'd1,
		REQ_COMMIT  = 2'd2
	} req_type_t;

	// update command for the linked stack
	typedef struct packed {
		logic en;
		logic recover;
		logic pop;
		logic push;
	} spec_cmd_t;

	// remainder of a narrow index by a stack depth, binary long division
	function automatic logic [5:0] reduce_mod(logic [5:0] v, int unsigned n);
		logic [5:0] r;
		r = v;
		for (int k = 6; k >= 0; k--) begin
			if (32'(r) >= (n << k)) begin
				r = r - 6'(n << k);
			end
		end
		return r;
	endfunction

endpackage

// ===== hdl/lras_ifs.sv =====
interface lras_req_if;
	import lras_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [REQ_W-1:0]     req_type;
	logic                 is_call;
	logic                 is_ret;
	logic [ADDR_W-1:0]    push_addr;
	logic [IDX_W-1:0]     snap_top_idx;
	logic [IDX_W-1:0]     snap_wr_idx;
	logic [CSP_W-1:0]     snap_commit_spec_top;
	logic [VBITS_W-1:0]   snap_valid_bits;

	modport source (
		output valid, req_type, is_call, is_ret, push_addr,
		output snap_top_idx, snap_wr_idx, snap_commit_spec_top, snap_valid_bits,
		input  ready
	);
	modport sink (
		input  valid, req_type, is_call, is_ret, push_addr,
		input  snap_top_idx, snap_wr_idx, snap_commit_spec_top, snap_valid_bits,
		output ready
	);
endinterface

interface lras_rsp_if;
	import lras_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [ADDR_W-1:0]    target_addr;
	logic                 target_valid;
	logic [IDX_W-1:0]     out_top_idx;
	logic [IDX_W-1:0]     out_wr_idx;
	logic [CSP_W-1:0]     out_commit_spec_top;
	logic [VBITS_W-1:0]   out_valid_bits;

	modport source (
		output valid, target_addr, target_valid, out_top_idx, out_wr_idx,
		output out_commit_spec_top, out_valid_bits,
		input  ready
	);
	modport sink (
		input  valid, target_addr, target_valid, out_top_idx, out_wr_idx,
		input  out_commit_spec_top, out_valid_bits,
		output ready
	);
endinterface

// ===== hdl/linked_return_address_stack_unit.sv =====
// flow: a request is captured in the input register, and the result of a predict is then
// written to the result register once that register has room; recover and commit give no result
// throughput: one request per cycle while no predict waits for a full result register;
// the stack pointers and valid bits that the next request reads update as each request fires
// reset: pointers and valid bits clear at once, but the commit pointers go to the last entry; stack
// entries read as 0x80000000 until written, tracked by per-entry written flags, so no clearing pass
module linked_return_address_stack_unit #(
	parameter int unsigned SPEC_ENTRIES   = lras_pkg::SPEC_ENTRIES_DEF,
	parameter int unsigned COMMIT_ENTRIES = lras_pkg::COMMIT_ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	lras_req_if.sink    req,
	lras_rsp_if.source  rsp
);
	import lras_pkg::*;

	localparam int unsigned IW   = $clog2(SPEC_ENTRIES);
	localparam int unsigned CW   = $clog2(COMMIT_ENTRIES);
	localparam int unsigned VX_W = SPEC_ENTRIES + VBITS_W;
	localparam logic [CW-1:0] CLAST = CW'(COMMIT_ENTRIES - 1);

	// input register
	logic                 v_s1;
	logic [REQ_W-1:0]     req_type_s1;
	logic                 is_call_s1;
	logic                 is_ret_s1;
	logic [ADDR_W-1:0]    push_addr_s1;
	logic [IDX_W-1:0]     snap_top_s1;
	logic [IDX_W-1:0]     snap_wr_s1;
	logic [CSP_W-1:0]     snap_csp_s1;
	logic [VBITS_W-1:0]   snap_valid_s1;

	// result register
	logic                 v_s2;
	logic [ADDR_W-1:0]    target_addr_s2;
	logic                 target_valid_s2;
	logic [IDX_W-1:0]     top_idx_s2;
	logic [IDX_W-1:0]     wr_idx_s2;
	logic [CSP_W-1:0]     csp_s2;
	logic [VBITS_W-1:0]   valid_bits_s2;

	// commit stack, its commit top pointer and its speculative pointer
	logic [CW-1:0]             csp_q;
	logic [CW-1:0]             ct_q;
	logic [COMMIT_ENTRIES-1:0] cwritten_q;
	logic [ADDR_W-1:0]         caddr_mem [COMMIT_ENTRIES];

	logic is_pred, is_rec, is_cmt;
	logic res_free, fire;
	spec_cmd_t spec_cmd;

	logic [IW-1:0]           snap_top_red, snap_wr_red;
	logic [CW-1:0]           snap_csp_red;
	logic [VX_W-1:0]         snap_valid_x;
	logic [IW-1:0]           top_idx, wr_idx;
	logic [SPEC_ENTRIES-1:0] valid_bits;
	logic [VX_W-1:0]         valid_bits_x;
	logic                    top_hit;
	logic [ADDR_W-1:0]       spec_top_addr;
	logic [ADDR_W-1:0]       commit_top_addr;
	logic [CW-1:0]           csp0, csp1, csp2;
	logic [CW-1:0]           ct_inc, ct_dec;

	// request decode, the unused code does nothing
	always_comb begin
		is_pred = 1'b0;
		is_rec  = 1'b0;
		is_cmt  = 1'b0;
		unique case (req_type_s1)
			REQ_PREDICT: is_pred = 1'b1;
			REQ_RECOVER: is_rec  = 1'b1;
			REQ_COMMIT:  is_cmt  = 1'b1;
			default: ;
		endcase
	end

	// a predict waits only for room in the result register
	assign res_free  = !v_s2 || rsp.ready;
	assign fire      = v_s1 && (!is_pred || res_free);
	assign req.ready = !v_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (req.ready) begin
			v_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_type_s1   <= req.req_type;
			is_call_s1    <= req.is_call;
			is_ret_s1     <= req.is_ret;
			push_addr_s1  <= req.push_addr;
			snap_top_s1   <= req.snap_top_idx;
			snap_wr_s1    <= req.snap_wr_idx;
			snap_csp_s1   <= req.snap_commit_spec_top;
			snap_valid_s1 <= req.snap_valid_bits;
		end
	end

	// snapshot indices wrap to the stack depths, excess valid bits drop
	assign snap_top_red = IW'(reduce_mod(6'(snap_top_s1), SPEC_ENTRIES));
	assign snap_wr_red  = IW'(reduce_mod(6'(snap_wr_s1), SPEC_ENTRIES));
	assign snap_csp_red = CW'(reduce_mod(6'(snap_csp_s1), COMMIT_ENTRIES));
	assign snap_valid_x = VX_W'(snap_valid_s1);

	assign spec_cmd.en      = fire && (is_pred || is_rec);
	assign spec_cmd.recover = is_rec;
	assign spec_cmd.pop     = is_ret_s1;
	assign spec_cmd.push    = is_call_s1;

	lras_spec_stack #(
		.SPEC_ENTRIES (SPEC_ENTRIES)
	) u_spec_stack (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (spec_cmd),
		.push_addr  (push_addr_s1),
		.snap_top   (snap_top_red),
		.snap_wr    (snap_wr_red),
		.snap_valid (snap_valid_x[SPEC_ENTRIES-1:0]),
		.top_idx    (top_idx),
		.wr_idx     (wr_idx),
		.valid_bits (valid_bits),
		.top_hit    (top_hit),
		.top_addr   (spec_top_addr)
	);

	// speculative commit pointer moves down on every pop and up on every push, kept on commit
	always_comb begin
		csp0 = is_rec ? snap_csp_red : csp_q;
		csp1 = csp0;
		if (is_ret_s1) begin
			csp1 = (csp0 == '0) ? CLAST : csp0 - 1'b1;
		end
		csp2 = csp1;
		if (is_call_s1) begin
			csp2 = (csp1 == CLAST) ? '0 : csp1 + 1'b1;
		end
	end

	assign ct_inc = (ct_q == CLAST) ? '0 : ct_q + 1'b1;
	assign ct_dec = (ct_q == '0) ? CLAST : ct_q - 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			csp_q      <= CLAST;
			ct_q       <= CLAST;
			cwritten_q <= '0;
		end else begin
			if (spec_cmd.en) begin
				csp_q <= csp2;
			end
			// commit: a call wins over a return
			if (fire && is_cmt) begin
				priority if (is_call_s1) begin
					ct_q               <= ct_inc;
					cwritten_q[ct_inc] <= 1'b1;
				end else if (is_ret_s1) begin
					ct_q <= ct_dec;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && is_cmt && is_call_s1) begin
			caddr_mem[ct_inc] <= push_addr_s1;
		end
	end

	assign commit_top_addr = cwritten_q[csp_q] ? caddr_mem[csp_q] : RESET_ADDR;
	assign valid_bits_x    = VX_W'(valid_bits);

	// result register, holds while the consumer stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (fire && is_pred) begin
			v_s2 <= 1'b1;
		end else if (rsp.ready) begin
			v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && is_pred) begin
			target_addr_s2  <= top_hit ? spec_top_addr : commit_top_addr;
			target_valid_s2 <= is_ret_s1;
			top_idx_s2      <= IDX_W'(top_idx);
			wr_idx_s2       <= IDX_W'(wr_idx);
			csp_s2          <= CSP_W'(csp_q);
			valid_bits_s2   <= valid_bits_x[VBITS_W-1:0];
		end
	end

	assign rsp.valid               = v_s2;
	assign rsp.target_addr         = target_addr_s2;
	assign rsp.target_valid        = target_valid_s2;
	assign rsp.out_top_idx         = top_idx_s2;
	assign rsp.out_wr_idx          = wr_idx_s2;
	assign rsp.out_commit_spec_top = csp_s2;
	assign rsp.out_valid_bits      = valid_bits_s2;

endmodule

// ===== hdl/lras_spec_stack.sv =====
module lras_spec_stack #(
	parameter int unsigned SPEC_ENTRIES = lras_pkg::SPEC_ENTRIES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  lras_pkg::spec_cmd_t               cmd,
	input  logic [lras_pkg::ADDR_W-1:0]       push_addr,
	input  logic [$clog2(SPEC_ENTRIES)-1:0]   snap_top,
	input  logic [$clog2(SPEC_ENTRIES)-1:0]   snap_wr,
	input  logic [SPEC_ENTRIES-1:0]           snap_valid,
	output logic [$clog2(SPEC_ENTRIES)-1:0]   top_idx,
	output logic [$clog2(SPEC_ENTRIES)-1:0]   wr_idx,
	output logic [SPEC_ENTRIES-1:0]           valid_bits,
	output logic                              top_hit,
	output logic [lras_pkg::ADDR_W-1:0]       top_addr
);
	import lras_pkg::*;

	localparam int unsigned IW = $clog2(SPEC_ENTRIES);
	localparam logic [IW-1:0] LAST = IW'(SPEC_ENTRIES - 1);

	logic [IW-1:0]           top_q;
	logic [IW-1:0]           wr_q;
	logic [SPEC_ENTRIES-1:0] valid_q;
	logic [SPEC_ENTRIES-1:0] written_q;
	logic [ADDR_W-1:0]       addr_mem [SPEC_ENTRIES];
	logic [IW-1:0]           link_mem [SPEC_ENTRIES];

	logic [IW-1:0]           top0, top1, top2;
	logic [IW-1:0]           wr0, wr2;
	logic [SPEC_ENTRIES-1:0] val0, val1, val2;
	logic                    hit0;
	logic [IW-1:0]           link0;

	always_comb begin
		top0  = cmd.recover ? snap_top : top_q;
		wr0   = cmd.recover ? snap_wr : wr_q;
		val0  = cmd.recover ? snap_valid : valid_q;
		hit0  = val0[top0];
		link0 = written_q[top0] ? link_mem[top0] : '0;

		// pop: follow the link of a valid top
		top1 = top0;
		val1 = val0;
		if (cmd.pop && hit0) begin
			top1 = link0;
			val1 = val0 & ~(SPEC_ENTRIES'(1) << top0);
		end

		// push: new entry at the write index
		top2 = top1;
		wr2  = wr0;
		val2 = val1;
		if (cmd.push) begin
			top2 = wr0;
			wr2  = (wr0 == LAST) ? '0 : wr0 + 1'b1;
			val2 = val1 | (SPEC_ENTRIES'(1) << wr0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q     <= '0;
			wr_q      <= '0;
			valid_q   <= '0;
			written_q <= '0;
		end else if (cmd.en) begin
			top_q   <= top2;
			wr_q    <= wr2;
			valid_q <= val2;
			if (cmd.push) begin
				written_q[wr0] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.en && cmd.push) begin
			addr_mem[wr0] <= push_addr;
			link_mem[wr0] <= top1;
		end
	end

	assign top_idx    = top_q;
	assign wr_idx     = wr_q;
	assign valid_bits = valid_q;
	assign top_hit    = valid_q[top_q];
	assign top_addr   = written_q[top_q] ? addr_mem[top_q] : RESET_ADDR;

endmodule

// ===== hdl/lras_checker.sv =====
module lras_checker #(
	parameter int unsigned SPEC_ENTRIES   = lras_pkg::SPEC_ENTRIES_DEF,
	parameter int unsigned COMMIT_ENTRIES = lras_pkg::COMMIT_ENTRIES_DEF
) (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           req_ready,
	input logic                           rsp_valid,
	input logic                           rsp_ready,
	input logic [lras_pkg::ADDR_W-1:0]    target_addr,
	input logic [lras_pkg::IDX_W-1:0]     out_top_idx,
	input logic [lras_pkg::IDX_W-1:0]     out_wr_idx,
	input logic [lras_pkg::CSP_W-1:0]     out_commit_spec_top,
	input logic [lras_pkg::VBITS_W-1:0]   out_valid_bits
);
	import lras_pkg::*;

	localparam int unsigned VX_W = SPEC_ENTRIES + VBITS_W;

	logic [VX_W-1:0] vbits_x;
	assign vbits_x = VX_W'(out_valid_bits);

	// a stalled result keeps its target address and valid bits
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(target_addr)
			&& $stable(out_valid_bits))
		else $error("result changed while stalled");

	// with the result register empty the input side never stalls
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |-> req_ready)
		else $error("input stalled with empty result register");

	// snapshot pointers stay inside the stack depths
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (32'(out_top_idx) < SPEC_ENTRIES) && (32'(out_wr_idx) < SPEC_ENTRIES)
			&& (32'(out_commit_spec_top) < COMMIT_ENTRIES))
		else $error("snapshot pointer out of range");

	// no valid bit above the linked stack depth
	a_vbits_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (vbits_x >> SPEC_ENTRIES) == '0)
		else $error("valid bit beyond stack depth");

endmodule

bind linked_return_address_stack_unit lras_checker #(
	.SPEC_ENTRIES   (SPEC_ENTRIES),
	.COMMIT_ENTRIES (COMMIT_ENTRIES)
) u_lras_checker (
	.clk                 (clk),
	.arst_n              (arst_n),
	.req_ready           (req.ready),
	.rsp_valid           (rsp.valid),
	.rsp_ready           (rsp.ready),
	.target_addr         (rsp.target_addr),
	.out_top_idx         (rsp.out_top_idx),
	.out_wr_idx          (rsp.out_wr_idx),
	.out_commit_spec_top (rsp.out_commit_spec_top),
	.out_valid_bits      (rsp.out_valid_bits)
);
